// ===== rtl/core/circle_segment_contact_top_defines.svh =====
// ----------------------------------------------------------------------------
// circle_segment_contact_top_defines
// assertion macros shared by the contact pipeline files
// ----------------------------------------------------------------------------
`ifndef CIRCLE_SEGMENT_CONTACT_TOP_DEFINES_SVH
`define CIRCLE_SEGMENT_CONTACT_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define CSC_ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("csc assertion failed");
// next-cycle implication
`define CSC_ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("csc assertion failed");
`else
`define CSC_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define CSC_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/csc_pkg.sv =====
// ----------------------------------------------------------------------------
// csc_pkg
// types and constants of the circle to segment contact pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package csc_pkg;

	localparam int ROOT_W = 31;            // width of the cap distance root
	localparam int RAD_W  = 2 * ROOT_W;    // radicand width
	localparam int D2_W   = 46;            // squared cap distance after the radius test
	localparam int QUO_W  = 15;            // width of a normal quotient
	localparam int NORM_ONE = 16384;       // unit length in Q1.14
	localparam logic [22:0] DEPTH_MAX = 23'h7FFFFF;

	// one input transaction
	typedef struct packed {
		logic signed [23:0] pred_x;
		logic signed [23:0] pred_y;
		logic signed [23:0] cur_x;
		logic signed [23:0] cur_y;
		logic        [22:0] radius;
		logic signed [23:0] seg_x;
		logic signed [23:0] seg_y;
		logic signed [15:0] norm_x;
		logic signed [15:0] norm_y;
		logic        [22:0] seg_len;
		logic        [15:0] item_tag;
	} csc_item_t;

	// one result transaction
	typedef struct packed {
		logic               hit;
		logic        [22:0] depth;
		logic signed [15:0] cnorm_x;
		logic signed [15:0] cnorm_y;
		logic signed [23:0] cpoint_x;
		logic signed [23:0] cpoint_y;
		logic        [15:0] out_tag;
	} csc_result_t;

	// geometry after the side, face and cap tests
	typedef struct packed {
		logic               hit;
		logic               cap;
		logic        [22:0] depth_face;
		logic   [D2_W-1:0]  d2;
		logic signed [24:0] dx;
		logic signed [24:0] dy;
		logic signed [23:0] px;
		logic signed [23:0] py;
		logic        [22:0] radius;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic        [15:0] tag;
	} csc_geo_t;

	// geometry plus cap distance root (8 fractional bits)
	typedef struct packed {
		csc_geo_t           geo;
		logic [ROOT_W-1:0]  root;
	} csc_root_t;

	// root stage plus normal quotient magnitudes
	typedef struct packed {
		csc_root_t          rt;
		logic [QUO_W-1:0]   qx;
		logic [QUO_W-1:0]   qy;
	} csc_quot_t;

endpackage

`default_nettype wire

// ===== rtl/core/csc_stream_if.sv =====
// ----------------------------------------------------------------------------
// csc_stream_if
// valid/ready stream channel with a typed payload
// ----------------------------------------------------------------------------
`default_nettype none

interface csc_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/csc_front.sv =====
// ----------------------------------------------------------------------------
// csc_front
// dot products, side/face tests, cap selection and squared cap distance
// ----------------------------------------------------------------------------
`default_nettype none

module csc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  csc_pkg::csc_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output csc_pkg::csc_geo_t   out_data
);
	import csc_pkg::*;

	localparam int NS = 7;

	logic [NS-1:0] vld_q;
	logic [NS:0]   rdy;

	// stage ready chain, a bubble can always be filled
	always_comb begin
		rdy[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k + 1];
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[NS-1];

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k - 1];
			end
		end
	end

	// stage 1: offsets and end point terms
	csc_item_t          it_s1;
	logic signed [24:0] tx_s1, ty_s1, cxs_s1, cys_s1;
	logic signed [39:0] elx_s1, ely_s1;
	logic signed [23:0] len_sx;

	assign len_sx = $signed({1'b0, in_data.seg_len});

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			it_s1  <= in_data;
			tx_s1  <= 25'(in_data.pred_x) - 25'(in_data.seg_x);
			ty_s1  <= 25'(in_data.pred_y) - 25'(in_data.seg_y);
			cxs_s1 <= 25'(in_data.cur_x) - 25'(in_data.seg_x);
			cys_s1 <= 25'(in_data.cur_y) - 25'(in_data.seg_y);
			elx_s1 <= -(40'(in_data.norm_y) * 40'(len_sx));
			ely_s1 <= 40'(in_data.norm_x) * 40'(len_sx);
		end
	end

	// stage 2: products and end point offset
	csc_item_t          it_s2;
	logic signed [24:0] tx_s2, ty_s2;
	logic signed [40:0] txnx_s2, tyny_s2, cxnx_s2, cyny_s2, txny_s2, tynx_s2;
	logic signed [27:0] edx_s2, edy_s2;
	logic signed [39:0] rlx, rly;
	logic signed [27:0] ex, ey;

	always_comb begin
		rlx = (elx_s1 + 40'sd8192) >>> 14;
		rly = (ely_s1 + 40'sd8192) >>> 14;
		ex  = 28'(it_s1.seg_x) + 28'(rlx);
		ey  = 28'(it_s1.seg_y) + 28'(rly);
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			it_s2   <= it_s1;
			tx_s2   <= tx_s1;
			ty_s2   <= ty_s1;
			txnx_s2 <= 41'(tx_s1) * 41'(it_s1.norm_x);
			tyny_s2 <= 41'(ty_s1) * 41'(it_s1.norm_y);
			cxnx_s2 <= 41'(cxs_s1) * 41'(it_s1.norm_x);
			cyny_s2 <= 41'(cys_s1) * 41'(it_s1.norm_y);
			txny_s2 <= 41'(tx_s1) * 41'(it_s1.norm_y);
			tynx_s2 <= 41'(ty_s1) * 41'(it_s1.norm_x);
			edx_s2  <= 28'(it_s1.pred_x) - ex;
			edy_s2  <= 28'(it_s1.pred_y) - ey;
		end
	end

	// stage 3: dot product sums
	csc_item_t          it_s3;
	logic signed [24:0] tx_s3, ty_s3;
	logic signed [27:0] edx_s3, edy_s3;
	logic signed [41:0] dreal_s3, dpred_s3, s_s3;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			it_s3    <= it_s2;
			tx_s3    <= tx_s2;
			ty_s3    <= ty_s2;
			edx_s3   <= edx_s2;
			edy_s3   <= edy_s2;
			dreal_s3 <= 42'(cxnx_s2) + 42'(cyny_s2);
			dpred_s3 <= 42'(txnx_s2) + 42'(tyny_s2);
			s_s3     <= 42'(tynx_s2) - 42'(txny_s2);
		end
	end

	// stage 4: penetration, side test and region select
	csc_item_t          it_s4;
	logic               nohit_s4, cap_s4;
	logic signed [27:0] dx_s4, dy_s4;
	logic signed [43:0] pen_s4;
	logic signed [43:0] pen;
	logic               start_c, end_c;

	always_comb begin
		pen     = 44'($signed({1'b0, it_s3.radius, 14'b0})) - 44'(dpred_s3);
		start_c = s_s3[41];
		end_c   = 43'(s_s3) > 43'($signed({1'b0, it_s3.seg_len, 14'b0}));
	end

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			it_s4    <= it_s3;
			pen_s4   <= pen;
			nohit_s4 <= dreal_s3[41] || pen[43] || (pen == '0);
			cap_s4   <= start_c || end_c;
			dx_s4    <= start_c ? 28'(tx_s3) : edx_s3;
			dy_s4    <= start_c ? 28'(ty_s3) : edy_s3;
		end
	end

	// stage 5: squares and face depth
	csc_item_t          it_s5;
	logic               nohit_s5, cap_s5;
	logic signed [27:0] dx_s5, dy_s5;
	logic        [55:0] sqx_s5, sqy_s5;
	logic        [45:0] rr_s5;
	logic        [22:0] fdep_s5;
	logic signed [43:0] kf;

	assign kf = (pen_s4 + 44'sd8192) >>> 14;

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			it_s5    <= it_s4;
			nohit_s5 <= nohit_s4;
			cap_s5   <= cap_s4;
			dx_s5    <= dx_s4;
			dy_s5    <= dy_s4;
			sqx_s5   <= 56'(dx_s4) * 56'(dx_s4);
			sqy_s5   <= 56'(dy_s4) * 56'(dy_s4);
			rr_s5    <= 46'(it_s4.radius) * 46'(it_s4.radius);
			fdep_s5  <= (kf > 44'($signed({1'b0, DEPTH_MAX}))) ? DEPTH_MAX : kf[22:0];
		end
	end

	// stage 6: squared cap distance
	csc_item_t          it_s6;
	logic               nohit_s6, cap_s6;
	logic signed [27:0] dx_s6, dy_s6;
	logic        [56:0] d2_s6;
	logic        [45:0] rr_s6;
	logic        [22:0] fdep_s6;

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			it_s6    <= it_s5;
			nohit_s6 <= nohit_s5;
			cap_s6   <= cap_s5;
			dx_s6    <= dx_s5;
			dy_s6    <= dy_s5;
			d2_s6    <= 57'(sqx_s5) + 57'(sqy_s5);
			rr_s6    <= rr_s5;
			fdep_s6  <= fdep_s5;
		end
	end

	// stage 7: cap radius test, pack geometry
	csc_geo_t geo_s7;

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			geo_s7.hit        <= !nohit_s6 && !(cap_s6 && (d2_s6 > 57'(rr_s6)));
			geo_s7.cap        <= cap_s6;
			geo_s7.depth_face <= fdep_s6;
			geo_s7.d2         <= d2_s6[D2_W-1:0];
			geo_s7.dx         <= 25'(dx_s6);
			geo_s7.dy         <= 25'(dy_s6);
			geo_s7.px         <= it_s6.pred_x;
			geo_s7.py         <= it_s6.pred_y;
			geo_s7.radius     <= it_s6.radius;
			geo_s7.nx         <= it_s6.norm_x;
			geo_s7.ny         <= it_s6.norm_y;
			geo_s7.tag        <= it_s6.item_tag;
		end
	end

	assign out_data = geo_s7;

endmodule

`default_nettype wire

// ===== rtl/core/csc_sqrt.sv =====
// ----------------------------------------------------------------------------
// csc_sqrt
// pipelined digit-by-digit square root, one root bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module csc_sqrt (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  csc_pkg::csc_geo_t   in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output csc_pkg::csc_root_t  out_data
);
	import csc_pkg::*;

	localparam int NS    = ROOT_W;
	localparam int REM_W = ROOT_W + 1;

	typedef struct packed {
		csc_geo_t           geo;
		logic [RAD_W-1:0]   rad;
		logic [REM_W-1:0]   rem;
		logic [ROOT_W-1:0]  root;
	} sq_stage_t;

	// one root bit: bring down two radicand bits, try root*4+1
	function automatic sq_stage_t sq_step(sq_stage_t a);
		sq_stage_t        b;
		logic [REM_W+1:0] rem2;
		logic [REM_W+1:0] trial;
		b     = a;
		rem2  = {a.rem, a.rad[RAD_W-1 -: 2]};
		trial = {1'b0, a.root, 2'b01};
		b.rad = a.rad << 2;
		if (rem2 >= trial) begin
			b.rem  = REM_W'(rem2 - trial);
			b.root = {a.root[ROOT_W-2:0], 1'b1};
		end else begin
			b.rem  = REM_W'(rem2);
			b.root = {a.root[ROOT_W-2:0], 1'b0};
		end
		return b;
	endfunction

	logic [NS-1:0] vld_q;
	logic [NS:0]   rdy;
	sq_stage_t     pipe_q [NS];
	sq_stage_t     nxt    [NS];
	sq_stage_t     init;

	// stage ready chain
	always_comb begin
		rdy[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k + 1];
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k - 1];
			end
		end
	end

	// radicand is the squared distance with 16 extra fraction bits
	always_comb begin
		init.geo  = in_data;
		init.rad  = {in_data.d2, {(RAD_W - D2_W){1'b0}}};
		init.rem  = '0;
		init.root = '0;
		nxt[0]    = sq_step(init);
		for (int k = 1; k < NS; k++) begin
			nxt[k] = sq_step(pipe_q[k - 1]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (rdy[k]) pipe_q[k] <= nxt[k];
		end
	end

	assign out_data.geo  = pipe_q[NS-1].geo;
	assign out_data.root = pipe_q[NS-1].root;

endmodule

`default_nettype wire

// ===== rtl/core/csc_div.sv =====
// ----------------------------------------------------------------------------
// csc_div
// two-lane pipelined restoring divider for the cap normal, rounded half up
// ----------------------------------------------------------------------------
`default_nettype none

`include "circle_segment_contact_top_defines.svh"

module csc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  csc_pkg::csc_root_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output csc_pkg::csc_quot_t  out_data
);
	import csc_pkg::*;

	localparam int MAG_W = 25;
	localparam int NUM_W = MAG_W + 22;
	localparam int NS    = QUO_W + 1;

	typedef struct packed {
		csc_root_t         rt;
		logic [NUM_W-1:0]  rem_x;
		logic [NUM_W-1:0]  rem_y;
		logic [QUO_W-1:0]  quo_x;
		logic [QUO_W-1:0]  quo_y;
	} dv_stage_t;

	// one quotient bit on both lanes
	function automatic dv_stage_t dv_step(dv_stage_t a, int sh);
		dv_stage_t        b;
		logic [NUM_W-1:0] trial;
		b     = a;
		trial = NUM_W'(a.rt.root) << sh;
		if (a.rem_x >= trial) begin
			b.rem_x = a.rem_x - trial;
			b.quo_x = {a.quo_x[QUO_W-2:0], 1'b1};
		end else begin
			b.quo_x = {a.quo_x[QUO_W-2:0], 1'b0};
		end
		if (a.rem_y >= trial) begin
			b.rem_y = a.rem_y - trial;
			b.quo_y = {a.quo_y[QUO_W-2:0], 1'b1};
		end else begin
			b.quo_y = {a.quo_y[QUO_W-2:0], 1'b0};
		end
		return b;
	endfunction

	logic [NS-1:0] vld_q;
	logic [NS:0]   rdy;
	dv_stage_t     pipe_q [NS];
	dv_stage_t     nxt    [NS];
	logic [MAG_W-1:0] mag_x, mag_y;

	// stage ready chain
	always_comb begin
		rdy[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k + 1];
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k - 1];
			end
		end
	end

	// first stage forms |d| * 2^22 + root/2, then one bit per stage
	always_comb begin
		mag_x = in_data.geo.dx[MAG_W-1] ? $unsigned(-in_data.geo.dx) : $unsigned(in_data.geo.dx);
		mag_y = in_data.geo.dy[MAG_W-1] ? $unsigned(-in_data.geo.dy) : $unsigned(in_data.geo.dy);
		nxt[0].rt    = in_data;
		nxt[0].rem_x = {mag_x, 22'b0} + NUM_W'(in_data.root >> 1);
		nxt[0].rem_y = {mag_y, 22'b0} + NUM_W'(in_data.root >> 1);
		nxt[0].quo_x = '0;
		nxt[0].quo_y = '0;
		for (int k = 1; k < NS; k++) begin
			nxt[k] = dv_step(pipe_q[k - 1], QUO_W - k);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NS; k++) begin
			if (rdy[k]) pipe_q[k] <= nxt[k];
		end
	end

	assign out_data.rt = pipe_q[NS-1].rt;
	assign out_data.qx = pipe_q[NS-1].quo_x;
	assign out_data.qy = pipe_q[NS-1].quo_y;

	// a cap normal never exceeds unit length
	`CSC_ASSERT_IMP(a_quot_unit, clk, arst_n, out_valid && out_data.rt.geo.hit && out_data.rt.geo.cap && (out_data.rt.root != '0), (out_data.qx <= QUO_W'(NORM_ONE)) && (out_data.qy <= QUO_W'(NORM_ONE)))

endmodule

`default_nettype wire

// ===== rtl/core/csc_back.sv =====
// ----------------------------------------------------------------------------
// csc_back
// depth and normal selection, contact point and result packing
// ----------------------------------------------------------------------------
`default_nettype none

module csc_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  csc_pkg::csc_quot_t   in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output csc_pkg::csc_result_t out_data
);
	import csc_pkg::*;

	localparam int NS = 4;

	logic [NS-1:0] vld_q;
	logic [NS:0]   rdy;

	// stage ready chain
	always_comb begin
		rdy[NS] = out_ready;
		for (int k = NS - 1; k >= 0; k--) begin
			rdy[k] = !vld_q[k] || rdy[k + 1];
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = vld_q[NS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[0]) vld_q[0] <= in_valid;
			for (int k = 1; k < NS; k++) begin
				if (rdy[k]) vld_q[k] <= vld_q[k - 1];
			end
		end
	end

	// stage 1: pick depth and normal
	csc_geo_t           g;
	logic [31:0]        dcap;
	logic               capn;
	logic signed [15:0] qxs, qys;

	always_comb begin
		g    = in_data.rt.geo;
		dcap = 32'({1'b0, g.radius, 8'b0}) - 32'(in_data.rt.root) + 32'd128;
		capn = g.cap && (in_data.rt.root != '0);
		qxs  = $signed({1'b0, in_data.qx});
		qys  = $signed({1'b0, in_data.qy});
	end

	logic               hit_s1;
	logic        [22:0] depth_s1, r_s1;
	logic signed [15:0] cnx_s1, cny_s1;
	logic signed [23:0] px_s1, py_s1;
	logic        [15:0] tag_s1;

	always_ff @(posedge clk) begin
		if (rdy[0]) begin
			hit_s1   <= g.hit;
			depth_s1 <= g.cap ? dcap[30:8] : g.depth_face;
			cnx_s1   <= capn ? (g.dx[24] ? -qxs : qxs) : g.nx;
			cny_s1   <= capn ? (g.dy[24] ? -qys : qys) : g.ny;
			px_s1    <= g.px;
			py_s1    <= g.py;
			r_s1     <= g.radius;
			tag_s1   <= g.tag;
		end
	end

	// stage 2: normal times radius
	logic               hit_s2;
	logic        [22:0] depth_s2;
	logic signed [15:0] cnx_s2, cny_s2;
	logic signed [23:0] px_s2, py_s2;
	logic        [15:0] tag_s2;
	logic signed [39:0] mx_s2, my_s2;

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			hit_s2   <= hit_s1;
			depth_s2 <= depth_s1;
			cnx_s2   <= cnx_s1;
			cny_s2   <= cny_s1;
			px_s2    <= px_s1;
			py_s2    <= py_s1;
			tag_s2   <= tag_s1;
			mx_s2    <= 40'(cnx_s1) * 40'($signed({1'b0, r_s1}));
			my_s2    <= 40'(cny_s1) * 40'($signed({1'b0, r_s1}));
		end
	end

	// stage 3: round to Q.8
	logic               hit_s3;
	logic        [22:0] depth_s3;
	logic signed [15:0] cnx_s3, cny_s3;
	logic signed [23:0] px_s3, py_s3;
	logic        [15:0] tag_s3;
	logic signed [26:0] rx_s3, ry_s3;
	logic signed [39:0] rxw, ryw;

	always_comb begin
		rxw = (mx_s2 + 40'sd8192) >>> 14;
		ryw = (my_s2 + 40'sd8192) >>> 14;
	end

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			hit_s3   <= hit_s2;
			depth_s3 <= depth_s2;
			cnx_s3   <= cnx_s2;
			cny_s3   <= cny_s2;
			px_s3    <= px_s2;
			py_s3    <= py_s2;
			tag_s3   <= tag_s2;
			rx_s3    <= 27'(rxw);
			ry_s3    <= 27'(ryw);
		end
	end

	// stage 4: contact point with saturation, zero fields on no hit
	logic signed [27:0] cpx, cpy;
	logic signed [23:0] cpx_sat, cpy_sat;
	csc_result_t        res_s4;

	always_comb begin
		cpx = 28'(px_s3) - 28'(rx_s3);
		cpy = 28'(py_s3) - 28'(ry_s3);
		if (cpx > 28'sd8388607)       cpx_sat = 24'sh7FFFFF;
		else if (cpx < -28'sd8388608) cpx_sat = 24'sh800000;
		else                          cpx_sat = 24'(cpx);
		if (cpy > 28'sd8388607)       cpy_sat = 24'sh7FFFFF;
		else if (cpy < -28'sd8388608) cpy_sat = 24'sh800000;
		else                          cpy_sat = 24'(cpy);
	end

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			res_s4.hit      <= hit_s3;
			res_s4.depth    <= hit_s3 ? depth_s3 : '0;
			res_s4.cnorm_x  <= hit_s3 ? cnx_s3 : '0;
			res_s4.cnorm_y  <= hit_s3 ? cny_s3 : '0;
			res_s4.cpoint_x <= hit_s3 ? cpx_sat : '0;
			res_s4.cpoint_y <= hit_s3 ? cpy_sat : '0;
			res_s4.out_tag  <= tag_s3;
		end
	end

	assign out_data = res_s4;

endmodule

`default_nettype wire

// ===== rtl/core/circle_segment_contact_top.sv =====
// ----------------------------------------------------------------------------
// circle_segment_contact_top
// circle against line segment contact test, fully pipelined
// ----------------------------------------------------------------------------
//  channel | dir | payload      | handshake
//  item    | in  | csc_item_t   | valid/ready, taken when both high
//  result  | out | csc_result_t | valid/ready, taken when both high
//
// one transaction per cycle sustained while result is ready, one result per
// transaction, in order; 7 front stages, 31 square root stages (one root bit
// each), 16 divider stages (setup, then one quotient bit each), 4 back stages
// reset clears only the stage valid bits; the block is ready right after
// a stall at result backs up stage by stage; empty stages still take data
// ----------------------------------------------------------------------------
`default_nettype none

`include "circle_segment_contact_top_defines.svh"

module circle_segment_contact_top (
	input  logic         clk,
	input  logic         arst_n,
	csc_stream_if.sink   item,
	csc_stream_if.source result
);
	import csc_pkg::*;

	logic        f_valid, f_ready;
	csc_geo_t    f_data;
	logic        s_valid, s_ready;
	csc_root_t   s_data;
	logic        d_valid, d_ready;
	csc_quot_t   d_data;

	// tests and squared distance
	csc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_ready  (item.ready),
		.in_data   (item.data),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.out_data  (f_data)
	);

	// cap distance root
	csc_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.in_data   (f_data),
		.out_valid (s_valid),
		.out_ready (s_ready),
		.out_data  (s_data)
	);

	// cap normal division
	csc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_valid),
		.in_ready  (s_ready),
		.in_data   (s_data),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.out_data  (d_data)
	);

	// selection and contact point
	csc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.in_data   (d_data),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_data  (result.data)
	);

	// a miss carries only the tag
	`CSC_ASSERT_IMP(a_miss_zero, clk, arst_n, result.valid && !result.data.hit, (result.data.depth == '0) && (result.data.cnorm_x == '0) && (result.data.cnorm_y == '0) && (result.data.cpoint_x == '0) && (result.data.cpoint_y == '0))

	// input only blocks when the whole pipe is backed up from the output
	`CSC_ASSERT_IMP(a_stall_full, clk, arst_n, !item.ready, result.valid && !result.ready)

endmodule

`default_nettype wire

// ===== dv/circle_segment_contact_top_tb.sv =====
// ----------------------------------------------------------------------------
// circle_segment_contact_top_tb
// random and directed contact tests with an in-order scoreboard
// ----------------------------------------------------------------------------
// Drives circle/segment transactions in bursts while the result side stalls
// on its own pattern. Each accepted transaction is run through a behavioral
// contact calculator. Every result is checked field by field against the
// oldest expected contact.
// ----------------------------------------------------------------------------
`default_nettype none

import csc_pkg::*;

class contact_scoreboard;
	csc_result_t expected_q[$];
	int          errors;

	function new();
		errors = 0;
	endfunction

	// floor(sqrt(v)) on 64 bits
	static function longint unsigned int_sqrt(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// rounded to nearest, ties away from zero
	static function longint div_nearest(longint num, longint unsigned den);
		longint unsigned a, q;
		a = (num < 0) ? longint'(-num) : num;
		q = (a + den / 2) / den;
		return (num < 0) ? -longint'(q) : longint'(q);
	endfunction

	static function longint half_up14(longint v);
		return (v + 8192) >>> 14;
	endfunction

	static function longint clamp24(longint v);
		if (v > 8388607) return 8388607;
		if (v < -8388608) return -8388608;
		return v;
	endfunction

	// contact of one circle against one segment
	static function csc_result_t contact(csc_item_t it);
		csc_result_t res;
		longint px, py, cx, cy, rad, sx, sy, nx, ny, len;
		longint tx, ty, side, face, pen, tang, dep, cnx, cny, dx, dy;
		longint unsigned d2, q;
		px = it.pred_x; py = it.pred_y;
		cx = it.cur_x;  cy = it.cur_y;
		rad = longint'({1'b0, it.radius});
		sx = it.seg_x;  sy = it.seg_y;
		nx = it.norm_x; ny = it.norm_y;
		len = longint'({1'b0, it.seg_len});
		res = '0;
		res.out_tag = it.item_tag;
		tx = px - sx;
		ty = py - sy;
		side = (cx - sx) * nx + (cy - sy) * ny;
		face = tx * nx + ty * ny;
		pen = rad * 16384 - face;
		tang = -tx * ny + ty * nx;
		cnx = nx;
		cny = ny;
		if (side < 0 || pen <= 0) return res;
		if (tang < 0 || tang > len * 16384) begin
			// end-cap contact
			dx = tx;
			dy = ty;
			if (tang >= 0) begin
				dx = px - (sx + half_up14(-ny * len));
				dy = py - (sy + half_up14(nx * len));
			end
			d2 = longint'(dx * dx) + longint'(dy * dy);
			if (d2 > longint'(rad * rad)) return res;
			q = int_sqrt(d2 << 16);
			dep = longint'((longint'(rad) * 256 - q + 128) >> 8);
			if (q != 0) begin
				cnx = div_nearest(dx * 4194304, q);
				cny = div_nearest(dy * 4194304, q);
			end
		end else begin
			// face contact
			dep = (pen + 8192) / 16384;
			if (dep > 8388607) dep = 8388607;
		end
		res.hit = 1'b1;
		res.depth = dep[22:0];
		res.cnorm_x = cnx[15:0];
		res.cnorm_y = cny[15:0];
		res.cpoint_x = 24'(clamp24(px - half_up14(cnx * rad)));
		res.cpoint_y = 24'(clamp24(py - half_up14(cny * rad)));
		return res;
	endfunction

	function void note_item(csc_item_t it);
		expected_q.insert(expected_q.size(), contact(it));
	endfunction

	function void check_result(csc_result_t got);
		csc_result_t exp_r;
		string field;
		if (expected_q.size() == 0) begin
			$display("%0t: unexpected result transaction %p", $realtime, got);
			errors++;
			return;
		end
		exp_r = expected_q.pop_front();
		field = "";
		if (got.hit !== exp_r.hit) field = {field, " hit"};
		if (got.depth !== exp_r.depth) field = {field, " depth"};
		if (got.cnorm_x !== exp_r.cnorm_x) field = {field, " cnorm_x"};
		if (got.cnorm_y !== exp_r.cnorm_y) field = {field, " cnorm_y"};
		if (got.cpoint_x !== exp_r.cpoint_x) field = {field, " cpoint_x"};
		if (got.cpoint_y !== exp_r.cpoint_y) field = {field, " cpoint_y"};
		if (got.out_tag !== exp_r.out_tag) field = {field, " out_tag"};
		if (field != "") begin
			$display("%0t: mismatch in%s expected %p actual %p",
				$realtime, field, exp_r, got);
			errors++;
		end
	endfunction

	function int pending();
		return expected_q.size();
	endfunction
endclass

module circle_segment_contact_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 120;

	logic clk;
	logic arst_n;
	int   idle_cycles = 0;
	int   tag_count;

	csc_stream_if #(.T(csc_item_t))   item_ch();
	csc_stream_if #(.T(csc_result_t)) result_ch();

	contact_scoreboard contacts;

	circle_segment_contact_top u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_ch.sink),
		.result(result_ch.source)
	);

	always #2 clk = ~clk;

	// monitor both channels at the rising edge
	always @(posedge clk) begin
		if (item_ch.valid && item_ch.ready) contacts.note_item(item_ch.data);
		if (result_ch.valid && result_ch.ready) contacts.check_result(result_ch.data);
	end

	// watchdog on cycles with no transaction at all
	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// result side stalls: runs of ready and stall of random length
	initial begin : result_stall
		int run;
		result_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			run = $urandom_range(0, 3);
			@(negedge clk);
			if (run == 0) begin
				result_ch.ready <= 1'b1;
				repeat ($urandom_range(10, 60)) @(negedge clk);
			end else begin
				result_ch.ready <= 1'($urandom_range(0, 1));
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end
		end
	end

	// present one transaction and hold it until taken
	task automatic send(input csc_item_t it);
		@(negedge clk);
		item_ch.valid <= 1'b1;
		item_ch.data <= it;
		do @(posedge clk); while (!item_ch.ready);
	endtask

	task automatic pause(input int cycles);
		@(negedge clk);
		item_ch.valid <= 1'b0;
		repeat (cycles) @(negedge clk);
	endtask

	// wait until every expected result has come
	task automatic drain();
		while (contacts.pending() != 0) @(posedge clk);
	endtask

	function automatic csc_item_t fully_random();
		csc_item_t it;
		it = '0;
		it.pred_x = 24'($urandom); it.pred_y = 24'($urandom);
		it.cur_x = 24'($urandom);  it.cur_y = 24'($urandom);
		it.radius = 23'($urandom);
		it.seg_x = 24'($urandom);  it.seg_y = 24'($urandom);
		it.norm_x = 16'($urandom); it.norm_y = 16'($urandom);
		it.seg_len = 23'($urandom);
		it.item_tag = 16'($urandom);
		return it;
	endfunction

	// circle placed near a segment with a near-unit normal, x part sometimes zeroed
	function automatic csc_item_t near_segment(input int wide);
		csc_item_t it;
		real ang, nxr, nyr, rad, len, s_pos, d_pos, c_pos, sx, sy, px, py;
		int  span;
		it = '0;
		span = wide ? 8000000 : 65536;
		ang = $urandom_range(0, 62831) / 10000.0;
		nxr = $rtoi($cos(ang) * 16384.0 + $urandom_range(0, 2) - 1);
		nyr = $rtoi($sin(ang) * 16384.0 + $urandom_range(0, 2) - 1);
		if ($urandom_range(0, 7) == 0) nxr = 0;
		rad = $urandom_range(0, span);
		len = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, span);
		sx = $urandom_range(0, 4000000) - 2000000.0;
		sy = $urandom_range(0, 4000000) - 2000000.0;
		s_pos = $urandom_range(0, $rtoi(len + 2.0 * rad) + 2) - rad - 1.0;
		d_pos = $urandom_range(0, $rtoi(2.2 * rad) + 2) - 1.1 * rad - 1.0;
		c_pos = $urandom_range(0, 7) == 0 ? -real'($urandom_range(1, 1000))
			: $urandom_range(0, span);
		px = sx + (nxr * d_pos - nyr * s_pos) / 16384.0;
		py = sy + (nyr * d_pos + nxr * s_pos) / 16384.0;
		it.pred_x = 24'($rtoi(px));
		it.pred_y = 24'($rtoi(py));
		it.cur_x = 24'($rtoi(sx + nxr * c_pos / 16384.0));
		it.cur_y = 24'($rtoi(sy + nyr * c_pos / 16384.0));
		it.radius = 23'($rtoi(rad));
		it.seg_x = 24'($rtoi(sx));
		it.seg_y = 24'($rtoi(sy));
		it.norm_x = 16'($rtoi(nxr));
		it.norm_y = 16'($rtoi(nyr));
		it.seg_len = 23'($rtoi(len));
		it.item_tag = 16'($urandom);
		return it;
	endfunction

	task automatic directed_items();
		csc_item_t it;
		// extremes of every field
		it = '0;
		send(it);
		it = '1;
		send(it);
		it = fully_random();
		it.pred_x = 24'h7FFFFF; it.pred_y = 24'h800000; it.radius = 23'h7FFFFF;
		it.cur_x = 24'h7FFFFF;  it.cur_y = 24'h800000;
		it.seg_x = 24'h800000;  it.seg_y = 24'h7FFFFF;
		it.norm_x = 16'sd16384; it.norm_y = 16'sd0; it.seg_len = 23'h7FFFFF;
		send(it);
		it.norm_x = -16'sd16384; it.norm_y = 16'sd0;
		send(it);
		it.norm_x = 16'sd0; it.norm_y = -16'sd16384;
		send(it);
		it.norm_x = 16'sh7FFF; it.norm_y = 16'sh8000;
		send(it);
		// current centre behind the segment
		it = '0;
		it.norm_x = 16'sd16384; it.cur_x = -24'sd1; it.radius = 23'd1000;
		it.seg_len = 23'd5000; it.item_tag = 16'hFFFF;
		send(it);
		// no penetration of the face
		it.cur_x = 24'sd0; it.pred_x = 24'sd1000;
		send(it);
		// face hit whose depth rounds to zero
		it.radius = 23'd0; it.pred_x = -24'sd1; it.norm_x = 16'sd1;
		send(it);
		// start cap beyond the radius, then within it
		it = '0;
		it.norm_x = 16'sd16384; it.radius = 23'd256; it.seg_len = 23'd1024;
		it.pred_y = -24'sd300;
		send(it);
		it.pred_y = -24'sd100; it.pred_x = 24'sd50;
		send(it);
		// end cap hit
		it.pred_y = 24'sd1100;
		send(it);
		// zero-length cap vector at the end point, non-unit normal
		it = '0;
		it.norm_x = 16'sd16384; it.norm_y = 16'sd16384; it.seg_len = 23'd512;
		it.radius = 23'd700; it.pred_x = -24'sd512; it.pred_y = 24'sd512;
		it.item_tag = 16'h5A5A;
		send(it);
		// clamped contact point
		it = '0;
		it.norm_x = -16'sd16384; it.radius = 23'h7FFFFF; it.seg_len = 23'h7FFFFF;
		it.pred_x = 24'h7FFFFF; it.seg_x = 24'h7FFFFF; it.cur_x = 24'h7FFFF0;
		send(it);
		repeat (6) send(near_segment(1));
		pause(2);
	endtask

	initial begin : stimulus
		int sel, burst;
		clk = 1'b0;
		arst_n = 1'b0;
		tag_count = 0;
		contacts = new();
		item_ch.valid <= 1'b0;
		item_ch.data <= '0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		directed_items();

		// random bursts, mostly well-formed geometry
		while (tag_count < 700) begin
			burst = $urandom_range(1, 40);
			repeat (burst) begin
				sel = $urandom_range(0, 9);
				if (sel < 7) send(near_segment(0));
				else if (sel < 8) send(near_segment(1));
				else send(fully_random());
				tag_count++;
			end
			if (tag_count > 350 && tag_count <= 350 + burst) begin
				// hold off until the pipeline has fully drained
				pause(0);
				drain();
			end else if ($urandom_range(0, 2) != 0) begin
				pause($urandom_range(0, 12));
			end
		end
		pause(0);

		drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (contacts.errors == 0 && contacts.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end
endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl/core
rtl/core/csc_pkg.sv
rtl/core/csc_stream_if.sv
rtl/core/csc_front.sv
rtl/core/csc_sqrt.sv
rtl/core/csc_div.sv
rtl/core/csc_back.sv
rtl/core/circle_segment_contact_top.sv
dv/circle_segment_contact_top_tb.sv
